### rtl/apsc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// apsc_pkg
// Shared codes and signature literals for the anchored protocol classifier.
// ---------------------------------------------------------------------------
package apsc_pkg;

   // signature classes
   localparam logic [2:0] CLASS_UNKNOWN  = 3'd0;
   localparam logic [2:0] CLASS_H1_RSP   = 3'd1;
   localparam logic [2:0] CLASS_H1_REQ   = 3'd2;
   localparam logic [2:0] CLASS_H2       = 3'd3;
   localparam logic [2:0] CLASS_TLS      = 3'd4;
   localparam logic [2:0] CLASS_WS       = 3'd5;

   // flow protocols
   localparam logic [1:0] PROTO_UNKNOWN  = 2'd0;
   localparam logic [1:0] PROTO_HTTP1    = 2'd1;
   localparam logic [1:0] PROTO_HTTP2    = 2'd2;
   localparam logic [1:0] PROTO_INVALID  = 2'd3;

   // candidate bits
   localparam int LIVE_RSP     = 0;
   localparam int LIVE_REQ     = 1;
   localparam int LIVE_H2      = 2;
   localparam int LIVE_TLS     = 3;
   localparam int LIVE_WS      = 4;
   localparam int METHOD_SHIFT = 5;
   localparam int NUM_METHODS  = 9;
   localparam int LIVE_W       = METHOD_SHIFT + NUM_METHODS;

   // request parse phases
   localparam logic [1:0] REQ_PHASE_METHOD  = 2'd0;
   localparam logic [1:0] REQ_PHASE_TARGET  = 2'd1;
   localparam logic [1:0] REQ_PHASE_VERSION = 2'd2;

   // register indexes
   localparam logic REG_DETECTOR_ENABLE = 1'b0;

   localparam logic [4:0] OFFSET_MAX = 5'd31;
   localparam logic [3:0] PHASE_OFFSET_MAX = 4'd15;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [7:0] HTTP_LIT [8] = '{"H", "T", "T", "P", "/", "1", ".", 8'h00};

   // preface padded to 32 entries, only the first 24 are compared
   localparam logic [4:0] H2_LEN = 5'd24;
   localparam logic [7:0] H2_LIT [32] = '{
      "P", "R", "I", " ", "*", " ", "H", "T", "T", "P", "/", "2", ".", "0",
      8'h0d, 8'h0a, 8'h0d, 8'h0a, "S", "M", 8'h0d, 8'h0a, 8'h0d, 8'h0a,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] METH_TXT [NUM_METHODS][8] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}};

   localparam logic [4:0] METH_LEN [NUM_METHODS] = '{
      5'd3, 5'd4, 5'd3, 5'd6, 5'd4, 5'd7, 5'd5, 5'd7, 5'd5};

   function automatic logic is_ver_digit(input logic [7:0] b);
      return (b == "0") || (b == "1");
   endfunction

endpackage

`default_nettype wire

### rtl/apsc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// apsc_req_if / apsc_rsp_if
// Valid/ready channels for payload bytes and classification results.
// ---------------------------------------------------------------------------
interface apsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;
   logic [1:0] flow_proto_in;

   modport source (output valid, data_byte, first_byte, last_byte, flow_proto_in,
                   input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, flow_proto_in,
                   output ready);
endinterface

interface apsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] detect_class;
   logic [1:0] flow_proto_out;

   modport source (output valid, detect_class, flow_proto_out, input ready);
   modport sink   (input valid, detect_class, flow_proto_out, output ready);
endinterface

`default_nettype wire

### rtl/anchored_protocol_signature_classifier_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// anchored_protocol_signature_classifier_unit
// Matches anchored HTTP/1, HTTP/2, TLS and WebSocket signatures on a byte
// stream and reports the class and flow protocol on each last byte.
// ---------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  req_if    in    valid/ready     data_byte, first_byte, last_byte, flow_proto_in
//  rsp_if    out   valid/ready     detect_class, flow_proto_out
//  csr (APB) in    psel/penable    detector_enable at byte address 0
//
//  One byte per cycle while no held result stalls a last byte. A byte is
//  matched while it sits in the input register, and a result is written
//  to the output register as its last byte leaves the input register.
//  Reset is synchronous; it clears match state, the enable and the valid flags of both stages.
//  A held result stalls only bytes carrying a last mark; other bytes pass.
// ---------------------------------------------------------------------------
module anchored_protocol_signature_classifier_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   apsc_req_if.sink         req_if,
   apsc_rsp_if.source       rsp_if,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import apsc_pkg::*;

   // configuration
   logic enable_ff;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic [1:0] in_proto_ff;

   // match state
   logic [4:0]        byte_offset_ff,  byte_offset_in;
   logic [LIVE_W-1:0] live_ff,         live_in;
   logic [1:0]        req_phase_ff,    req_phase_in;
   logic [3:0]        phase_offset_ff, phase_offset_in;
   logic              match_found_ff,  match_found_in;
   logic [2:0]        found_class_ff,  found_class_in;
   logic [1:0]        cached_proto_ff, cached_proto_in;

   // output stage
   logic       rsp_valid_ff;
   logic [2:0] rsp_class_ff, rsp_class_in;
   logic [1:0] rsp_proto_ff, rsp_proto_in;

   logic proc_go;
   logic out_free;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign proc_go      = in_valid_ff && (!in_last_ff || out_free);
   assign req_if.ready = !in_valid_ff || proc_go;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.detect_class   = rsp_class_ff;
   assign rsp_if.flow_proto_out = rsp_proto_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DETECTOR_ENABLE) ? {31'd0, enable_ff} : 32'd0;

   always_comb begin
      logic [4:0]        o;
      logic [LIVE_W-1:0] live;
      logic [1:0]        ph;
      logic [3:0]        po;
      logic              mf;
      logic [2:0]        fc;
      logic [1:0]        cp;
      logic [2:0]        cls;
      logic              ok;
      logic              to_target;
      logic [7:0]        b;

      b = in_byte_ff;
      if (in_first_ff) begin
         o    = '0;
         live = '1;
         ph   = REQ_PHASE_METHOD;
         po   = '0;
         mf   = 1'b0;
         fc   = CLASS_UNKNOWN;
         cp   = (in_proto_ff == PROTO_INVALID) ? PROTO_UNKNOWN : in_proto_ff;
      end else begin
         o    = byte_offset_ff;
         live = live_ff;
         ph   = req_phase_ff;
         po   = phase_offset_ff;
         mf   = match_found_ff;
         fc   = found_class_ff;
         cp   = cached_proto_ff;
      end
      cls       = CLASS_UNKNOWN;
      ok        = 1'b0;
      to_target = 1'b0;

      if (!mf) begin
         // HTTP/1 status line
         if (live[LIVE_RSP]) begin
            if (o < 5'd7)       ok = (b == HTTP_LIT[o[2:0]]);
            else if (o == 5'd7) ok = is_ver_digit(b);
            else if (o == 5'd8) ok = (b == CHAR_SPACE);
            else if (o <= 5'd11) ok = (b >= "0") && (b <= "9");
            else                ok = 1'b0;
            if (!ok) live[LIVE_RSP] = 1'b0;
            else if (o == 5'd11) cls = CLASS_H1_RSP;
         end

         // HTTP/2 preface
         if (live[LIVE_H2]) begin
            if ((o < H2_LEN) && (b == H2_LIT[o])) begin
               if (o == H2_LEN - 5'd1) cls = CLASS_H2;
            end else begin
               live[LIVE_H2] = 1'b0;
            end
         end

         // TLS record header
         if (live[LIVE_TLS]) begin
            if (o == 5'd0)      ok = (b == 8'h16) || (b == 8'h17);
            else if (o == 5'd1) ok = (b == 8'h03);
            else if (o == 5'd2) ok = (b <= 8'h03);
            else                ok = 1'b0;
            if (!ok) live[LIVE_TLS] = 1'b0;
            else if (o == 5'd2) cls = CLASS_TLS;
         end

         // WebSocket frame header, mask bit set
         if (live[LIVE_WS]) begin
            if (o == 5'd0)
               ok = (b == 8'h81) || (b == 8'h82) || (b == 8'h88) ||
                    (b == 8'h89) || (b == 8'h8a);
            else if (o == 5'd1) ok = b[7];
            else                ok = 1'b0;
            if (!ok) live[LIVE_WS] = 1'b0;
            else if (o == 5'd1) cls = CLASS_WS;
         end

         // HTTP/1 request line
         if (live[LIVE_REQ]) begin
            unique case (ph)
               REQ_PHASE_METHOD: begin
                  for (int m = 0; m < NUM_METHODS; m++) begin
                     if (live[METHOD_SHIFT + m]) begin
                        if (o < METH_LEN[m]) begin
                           if (b != METH_TXT[m][o[2:0]]) live[METHOD_SHIFT + m] = 1'b0;
                        end else if ((o == METH_LEN[m]) && (b == CHAR_SPACE)) begin
                           to_target = 1'b1;
                        end else begin
                           live[METHOD_SHIFT + m] = 1'b0;
                        end
                     end
                  end
                  if (to_target) begin
                     ph = REQ_PHASE_TARGET;
                     po = '0;
                  end else if (live[LIVE_W-1:METHOD_SHIFT] == '0) begin
                     live[LIVE_REQ] = 1'b0;
                  end
               end
               REQ_PHASE_TARGET: begin
                  if (b == CHAR_SPACE) begin
                     if (po != '0) begin
                        ph = REQ_PHASE_VERSION;
                        po = '0;
                     end else begin
                        live[LIVE_REQ] = 1'b0;   // empty target
                     end
                  end else begin
                     po = 4'd1;
                  end
               end
               REQ_PHASE_VERSION: begin
                  if (po < 4'd7)       ok = (b == HTTP_LIT[po[2:0]]);
                  else if (po == 4'd7) ok = is_ver_digit(b);
                  else                 ok = 1'b0;
                  if (!ok) live[LIVE_REQ] = 1'b0;
                  else if (po == 4'd7) cls = CLASS_H1_REQ;
                  if (po < PHASE_OFFSET_MAX) po = po + 4'd1;
               end
               default: begin
                  live[LIVE_REQ] = 1'b0;
               end
            endcase
         end

         if (cls != CLASS_UNKNOWN) begin
            mf = 1'b1;
            fc = cls;
         end
      end

      byte_offset_in  = (o < OFFSET_MAX) ? o + 5'd1 : o;
      live_in         = live;
      req_phase_in    = ph;
      phase_offset_in = po;
      match_found_in  = mf;
      found_class_in  = fc;
      cached_proto_in = cp;

      rsp_class_in = (enable_ff && mf) ? fc : CLASS_UNKNOWN;
      if (cp != PROTO_UNKNOWN)
         rsp_proto_in = cp;
      else if ((rsp_class_in == CLASS_H1_RSP) || (rsp_class_in == CLASS_H1_REQ))
         rsp_proto_in = PROTO_HTTP1;
      else if (rsp_class_in == CLASS_H2)
         rsp_proto_in = PROTO_HTTP2;
      else
         rsp_proto_in = PROTO_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         byte_offset_ff  <= '0;
         live_ff         <= '1;
         req_phase_ff    <= REQ_PHASE_METHOD;
         phase_offset_ff <= '0;
         match_found_ff  <= 1'b0;
         found_class_ff  <= CLASS_UNKNOWN;
         cached_proto_ff <= PROTO_UNKNOWN;
      end else begin
         if (psel && penable && pwrite && pready && (paddr[2] == REG_DETECTOR_ENABLE))
            enable_ff <= pwdata[0];

         if (req_if.ready)
            in_valid_ff <= req_if.valid;

         if (proc_go) begin
            byte_offset_ff  <= byte_offset_in;
            live_ff         <= live_in;
            req_phase_ff    <= req_phase_in;
            phase_offset_ff <= phase_offset_in;
            match_found_ff  <= match_found_in;
            found_class_ff  <= found_class_in;
            cached_proto_ff <= cached_proto_in;
         end

         if (proc_go && in_last_ff)
            rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff  <= req_if.data_byte;
         in_first_ff <= req_if.first_byte;
         in_last_ff  <= req_if.last_byte;
         in_proto_ff <= req_if.flow_proto_in;
      end
      if (proc_go && in_last_ff) begin
         rsp_class_ff <= rsp_class_in;
         rsp_proto_ff <= rsp_proto_in;
      end
   end

endmodule

`default_nettype wire
